>>> hdl/bis_pkg.sv
`default_nettype none

package bis_pkg;

  // Fixed field widths of the transaction payloads
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TLEN_W   = 11;
  localparam int unsigned BCNT_W   = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W    = 11;

  typedef enum logic [1:0] {
    OP_WR_DATA  = 2'd0,
    OP_WR_INDEX = 2'd1,
    OP_SEARCH   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_LENGTH = 1'b0,
    REG_BLOCK_COUNT  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_BOUND,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] key_value;
    logic [SLOT_W-1:0]       block_start;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic [TLEN_W-1:0] table_length;
    logic [BCNT_W-1:0] block_count;
  } cfg_regs_t;

endpackage

`default_nettype wire

>>> hdl/bis_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module bis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/bis_ctrl.sv
`default_nettype none

// Search sequencer: index walk, block bound fetch, data scan.
module bis_ctrl #(
  parameter int unsigned DATA_DEPTH  = 1024,
  parameter int unsigned INDEX_DEPTH = 32,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned DAW         = 10,
  parameter int unsigned IAW         = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire bis_pkg::in_item_t              in_item,
  input  wire bis_pkg::cfg_regs_t             cfg,
  output logic                                out_valid,
  output bis_pkg::out_item_t                  out_item,
  // data store
  output logic                                dat_we,
  output logic [DAW-1:0]                      dat_waddr,
  output logic [KEY_WIDTH-1:0]                dat_wdata,
  output logic [DAW-1:0]                      dat_raddr,
  input  wire logic [KEY_WIDTH-1:0]           dat_rdata,
  // index store: {max key, block start}
  output logic                                idx_we,
  output logic [IAW-1:0]                      idx_waddr,
  output logic [KEY_WIDTH+bis_pkg::SLOT_W-1:0] idx_wdata,
  output logic [IAW-1:0]                      idx_raddr,
  input  wire logic [KEY_WIDTH+bis_pkg::SLOT_W-1:0] idx_rdata
);

  localparam int unsigned SW = bis_pkg::SLOT_W;
  localparam int unsigned TW = bis_pkg::TLEN_W;
  localparam int unsigned BW = bis_pkg::BCNT_W;

  bis_pkg::state_t state_r, state_nxt;

  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [BW-1:0]               blocks_r, blocks_nxt;
  logic [TW-1:0]               len_r, len_nxt;
  logic [BW-1:0]               i_r, i_nxt;
  logic [TW-1:0]               cp_r, cp_nxt;
  logic [TW-1:0]               lim_r, lim_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        found_r, found_nxt;
  logic [SW-1:0]               pos_r, pos_nxt;

  logic signed [KEY_WIDTH-1:0] key_in;
  logic [BW-1:0]               blocks_eff;
  logic [TW-1:0]               len_eff;
  logic                        accept;
  logic                        is_search;
  logic signed [KEY_WIDTH-1:0] idx_key;
  logic [SW-1:0]               idx_start;
  logic [TW-1:0]               next_lim;
  logic                        key_above;
  logic                        last_walk;
  logic                        last_block;
  logic [BW-1:0]               i_inc;
  logic [TW:0]                 cp_inc;
  logic                        start_past_len;
  logic                        start_past_next;
  logic                        scan_end;
  logic                        key_hit;

  // Key narrowed or sign-extended to the stored width
  assign key_in = KEY_WIDTH'(in_item.key_value);

  assign blocks_eff = (int'(cfg.block_count) > INDEX_DEPTH) ? BW'(INDEX_DEPTH)
                                                             : cfg.block_count;
  assign len_eff    = (int'(cfg.table_length) > DATA_DEPTH) ? TW'(DATA_DEPTH)
                                                             : cfg.table_length;

  assign busy      = (state_r != bis_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign is_search = (in_item.opcode == bis_pkg::OP_SEARCH);

  assign idx_key   = $signed(idx_rdata[KEY_WIDTH+SW-1:SW]);
  assign idx_start = idx_rdata[SW-1:0];
  assign next_lim  = (int'(idx_start) > DATA_DEPTH) ? TW'(DATA_DEPTH) : {1'b0, idx_start};

  assign key_above       = key_r > idx_key;
  assign i_inc           = i_r + 1'b1;
  assign last_walk       = (i_inc == blocks_r);
  assign last_block      = (i_inc == blocks_r);
  assign cp_inc          = {1'b0, cp_r} + 1'b1;
  assign start_past_len  = ({1'b0, idx_start} >= len_r);
  assign start_past_next = (cp_r >= next_lim);
  assign scan_end        = (cp_inc >= {1'b0, lim_r});
  assign key_hit         = ($signed(dat_rdata) == key_r);

  // Writes go straight to the stores from idle
  assign dat_we    = accept && (in_item.opcode == bis_pkg::OP_WR_DATA) &&
                     (int'(in_item.slot) < DATA_DEPTH);
  assign dat_waddr = DAW'(in_item.slot);
  assign dat_wdata = key_in;
  assign idx_we    = accept && (in_item.opcode == bis_pkg::OP_WR_INDEX) &&
                     (int'(in_item.slot) < INDEX_DEPTH);
  assign idx_waddr = IAW'(in_item.slot);
  assign idx_wdata = {key_in, in_item.block_start};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bis_pkg::ST_IDLE: begin
        if (accept && is_search && (blocks_eff != '0)) begin
          state_nxt = bis_pkg::ST_WALK;
        end
      end
      bis_pkg::ST_WALK: begin
        if (key_above) begin
          if (last_walk) begin
            state_nxt = bis_pkg::ST_IDLE;
          end
        end else if (last_block) begin
          state_nxt = start_past_len ? bis_pkg::ST_IDLE : bis_pkg::ST_SCAN;
        end else begin
          state_nxt = bis_pkg::ST_BOUND;
        end
      end
      bis_pkg::ST_BOUND: begin
        state_nxt = start_past_next ? bis_pkg::ST_IDLE : bis_pkg::ST_SCAN;
      end
      bis_pkg::ST_SCAN: begin
        if (key_hit || scan_end) begin
          state_nxt = bis_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bis_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    key_nxt       = key_r;
    blocks_nxt    = blocks_r;
    len_nxt       = len_r;
    i_nxt         = i_r;
    cp_nxt        = cp_r;
    lim_nxt       = lim_r;
    out_valid_nxt = 1'b0;
    found_nxt     = 1'b0;
    pos_nxt       = '0;
    idx_raddr     = IAW'(i_r);
    dat_raddr     = DAW'(cp_r);
    case (state_r)
      bis_pkg::ST_IDLE: begin
        idx_raddr = '0;
        if (accept && is_search) begin
          key_nxt    = key_in;
          blocks_nxt = blocks_eff;
          len_nxt    = len_eff;
          i_nxt      = '0;
          // no blocks in use: answer at once
          if (blocks_eff == '0) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      bis_pkg::ST_WALK: begin
        if (key_above) begin
          i_nxt     = i_inc;
          idx_raddr = IAW'(i_inc);
          if (last_walk) begin
            out_valid_nxt = 1'b1;
          end
        end else if (last_block) begin
          // last block ends at the table length
          cp_nxt    = {1'b0, idx_start};
          lim_nxt   = len_r;
          dat_raddr = DAW'(idx_start);
          if (start_past_len) begin
            out_valid_nxt = 1'b1;
          end
        end else begin
          // fetch the following block's start for the bound
          cp_nxt    = {1'b0, idx_start};
          idx_raddr = IAW'(i_inc);
        end
      end
      bis_pkg::ST_BOUND: begin
        lim_nxt   = next_lim;
        dat_raddr = DAW'(cp_r);
        if (start_past_next) begin
          out_valid_nxt = 1'b1;
        end
      end
      bis_pkg::ST_SCAN: begin
        if (key_hit) begin
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
          pos_nxt       = cp_r[SW-1:0];
        end else begin
          cp_nxt    = cp_inc[TW-1:0];
          dat_raddr = DAW'(cp_inc);
          if (scan_end) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bis_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    blocks_r <= blocks_nxt;
    len_r    <= len_nxt;
    i_r      <= i_nxt;
    cp_r     <= cp_nxt;
    lim_r    <= lim_nxt;
    found_r  <= found_nxt;
    pos_r    <= pos_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_item.found    = found_r;
  assign out_item.position = pos_r;

endmodule

`default_nettype wire

>>> hdl/block_indexed_search_unit.sv
`default_nettype none

// Channel   Ports                          Handshake
// input     start, busy, in_item           taken when start high and busy low
// result    out_valid, out_item            one-cycle strobe, no backpressure
// config    cfg_we, cfg_index, cfg_wdata   written on any cycle with cfg_we high
//
// Writes (data entry, index entry) go straight to the stores; busy stays low.
// A search walks index entries (up to block_count, capped at INDEX_DEPTH),
// fetches the next block's start as bound for a non-final block, then scans
// data entries up to the block end; one memory read per cycle sets the pace.
// Result strobes in the cycle after the last compare, when a new start can be taken.
// rst_n (sync) clears sequencer and config registers, not the stores; no stall.
module block_indexed_search_unit #(
  parameter int unsigned DATA_DEPTH  = 1024,
  parameter int unsigned INDEX_DEPTH = 32,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input transactions
  input  wire logic                              start,
  output logic                                   busy,
  input  wire bis_pkg::in_item_t                 in_item,
  // results
  output logic                                   out_valid,
  output bis_pkg::out_item_t                     out_item,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bis_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int unsigned DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int unsigned IAW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
  localparam int unsigned IW  = KEY_WIDTH + bis_pkg::SLOT_W;

  bis_pkg::cfg_regs_t cfg_r, cfg_nxt;

  logic                 dat_we;
  logic [DAW-1:0]       dat_waddr;
  logic [KEY_WIDTH-1:0] dat_wdata;
  logic [DAW-1:0]       dat_raddr;
  logic [KEY_WIDTH-1:0] dat_rdata;
  logic                 idx_we;
  logic [IAW-1:0]       idx_waddr;
  logic [IW-1:0]        idx_wdata;
  logic [IAW-1:0]       idx_raddr;
  logic [IW-1:0]        idx_rdata;

  // Config registers; only to be written while no search is running, which the user must ensure (cfg_we is unchecked)
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bis_pkg::REG_TABLE_LENGTH: cfg_nxt.table_length = cfg_wdata[bis_pkg::TLEN_W-1:0];
        bis_pkg::REG_BLOCK_COUNT:  cfg_nxt.block_count  = cfg_wdata[bis_pkg::BCNT_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Data keys
  bis_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DATA_DEPTH),
    .AW    (DAW)
  ) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .raddr (dat_raddr),
    .rdata (dat_rdata)
  );

  // Index: block max key and block start in one word
  bis_ram #(
    .WIDTH (IW),
    .DEPTH (INDEX_DEPTH),
    .AW    (IAW)
  ) u_index_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .raddr (idx_raddr),
    .rdata (idx_rdata)
  );

  bis_ctrl #(
    .DATA_DEPTH  (DATA_DEPTH),
    .INDEX_DEPTH (INDEX_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .DAW         (DAW),
    .IAW         (IAW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_item  (out_item),
    .dat_we    (dat_we),
    .dat_waddr (dat_waddr),
    .dat_wdata (dat_wdata),
    .dat_raddr (dat_raddr),
    .dat_rdata (dat_rdata),
    .idx_we    (idx_we),
    .idx_waddr (idx_waddr),
    .idx_wdata (idx_wdata),
    .idx_raddr (idx_raddr),
    .idx_rdata (idx_rdata)
  );

endmodule

`default_nettype wire

>>> dv/block_indexed_search_unit_test.sv
`default_nettype none

// Block-level test of the indexed search unit.
// A shadow copy of both stores and both config registers is kept here and
// updated as each transaction is accepted. Every search is answered from that
// shadow at acceptance, queued, and matched against the result strobe.
// Searches that would touch a store entry never written are not issued, since
// the unit's answer is undefined there.
module block_indexed_search_unit_test;

  // Store depths; signed so bound math with a -1 end stays signed.
  localparam int DATA_DEPTH  = 1024;
  localparam int INDEX_DEPTH = 32;

  // Opcode outside the defined set; the unit must ignore it.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic signed [bis_pkg::KEY_W-1:0] KEY_LO = 32'sh8000_0000;
  localparam logic signed [bis_pkg::KEY_W-1:0] KEY_HI = 32'sh7FFF_FFFF;

  localparam int     CLK_HALF       = 6;
  localparam int     IDLE_PCT       = 26;
  localparam int     RANDOM_ITEMS   = 340;
  localparam int     MAX_REPORTS    = 10;
  // Longest search: up to 32 index entries walked, a bound fetch and up to 1024 entries scanned, plus margin.
  localparam int     TAIL_CYCLES    = 1100;
  localparam longint TIMEOUT_CYCLES = 5000000;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  bis_pkg::in_item_t             in_item;
  logic                          out_valid;
  bis_pkg::out_item_t            out_item;
  logic                          cfg_we;
  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bis_pkg::CFG_W-1:0]     cfg_wdata;

  // Shadow of the unit's state
  logic signed [bis_pkg::KEY_W-1:0] table_keys [DATA_DEPTH];
  bit                               table_set  [DATA_DEPTH];
  logic signed [bis_pkg::KEY_W-1:0] blk_max    [INDEX_DEPTH];
  logic [bis_pkg::SLOT_W-1:0]       blk_first  [INDEX_DEPTH];
  bit                               blk_set    [INDEX_DEPTH];
  logic [bis_pkg::TLEN_W-1:0]       len_reg;
  logic [bis_pkg::BCNT_W-1:0]       cnt_reg;

  // Answers owed by the unit, oldest first
  bis_pkg::out_item_t search_answers[$];

  int mismatch_count;
  int items_sent;
  bit steady;   // set: sender never idles

  block_indexed_search_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // Walk the index, then scan the chosen block, on the shadow state.
  // Returns 0 if any entry read on the way was never written.
  function automatic bit lookup_key(input logic signed [bis_pkg::KEY_W-1:0] key,
                                    output bis_pkg::out_item_t answer);
    int blocks;
    int len;
    int i;
    int s;
    int e;
    blocks = (cnt_reg > INDEX_DEPTH) ? INDEX_DEPTH : int'(cnt_reg);
    len    = (len_reg > DATA_DEPTH) ? DATA_DEPTH : int'(len_reg);
    answer = '0;
    i = 0;
    while (i < blocks) begin
      if (!blk_set[i]) return 1'b0;
      if (key > blk_max[i]) i++;
      else break;
    end
    if (i < blocks) begin
      s = int'(blk_first[i]);
      if (i == blocks - 1) begin
        e = len - 1;
      end else begin
        if (!blk_set[i + 1]) return 1'b0;
        e = int'(blk_first[i + 1]) - 1;
      end
      if (e > DATA_DEPTH - 1) e = DATA_DEPTH - 1;
      // empty or inverted block: loop never runs, not found
      while (s <= e) begin
        if (!table_set[s]) return 1'b0;
        if (table_keys[s] == key) begin
          answer.found    = 1'b1;
          answer.position = s[bis_pkg::SLOT_W-1:0];
          break;
        end
        s++;
      end
    end
    return 1'b1;
  endfunction

  task automatic idle_cycle();
    @(negedge clk);
    start = 1'b0;
  endtask

  // Drive one transaction, hold until taken, then update the shadow.
  // start is left high; the next call or an idle_cycle decides its fate.
  task automatic send_item(input bis_pkg::in_item_t item);
    bis_pkg::out_item_t answer;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) idle_cycle();
    end
    @(negedge clk);
    start   = 1'b1;
    in_item = item;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    case (item.opcode)
      bis_pkg::OP_WR_DATA: begin
        table_keys[item.slot] = item.key_value;
        table_set[item.slot]  = 1'b1;
      end
      bis_pkg::OP_WR_INDEX: begin
        // slots past the index depth are dropped
        if (item.slot < INDEX_DEPTH) begin
          blk_max[item.slot]   = item.key_value;
          blk_first[item.slot] = item.block_start;
          blk_set[item.slot]   = 1'b1;
        end
      end
      bis_pkg::OP_SEARCH: begin
        void'(lookup_key(item.key_value, answer));
        search_answers.push_back(answer);
      end
      default: ;  // reserved opcode: no effect, no result
    endcase
  endtask

  // Hold off new transactions until every owed answer is in,
  // then go on idling for as long as extra asks.
  task automatic wait_for_answers(input int extra);
    idle_cycle();
    while (search_answers.size() != 0) idle_cycle();
    repeat (extra) idle_cycle();
  endtask

  // Config writes only with the unit idle. A config write is registered,
  // so a short pause after the last answer is enough.
  task automatic write_reg(input bis_pkg::reg_idx_t idx,
                           input logic [bis_pkg::CFG_W-1:0] value);
    wait_for_answers(4);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      bis_pkg::REG_TABLE_LENGTH: len_reg = value[bis_pkg::TLEN_W-1:0];
      bis_pkg::REG_BLOCK_COUNT:  cnt_reg = value[bis_pkg::BCNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic put_data(input int slot, input logic signed [bis_pkg::KEY_W-1:0] key);
    bis_pkg::in_item_t it;
    it.opcode      = bis_pkg::OP_WR_DATA;
    it.slot        = bis_pkg::SLOT_W'(slot);
    it.key_value   = key;
    it.block_start = bis_pkg::SLOT_W'($urandom);  // unused field, still toggled
    send_item(it);
  endtask

  task automatic put_block(input int slot, input logic signed [bis_pkg::KEY_W-1:0] top,
                           input int first);
    bis_pkg::in_item_t it;
    it.opcode      = bis_pkg::OP_WR_INDEX;
    it.slot        = bis_pkg::SLOT_W'(slot);
    it.key_value   = top;
    it.block_start = bis_pkg::SLOT_W'(first);
    send_item(it);
  endtask

  // Issue a search unless it would read an unwritten entry.
  task automatic search_for(input logic signed [bis_pkg::KEY_W-1:0] key);
    bis_pkg::in_item_t  it;
    bis_pkg::out_item_t scratch;
    if (lookup_key(key, scratch)) begin
      it.opcode      = bis_pkg::OP_SEARCH;
      it.slot        = bis_pkg::SLOT_W'($urandom);
      it.key_value   = key;
      it.block_start = bis_pkg::SLOT_W'($urandom);
      send_item(it);
    end
  endtask

  // Noise: stray writes anywhere, index writes past the depth, reserved opcode.
  task automatic noise_item();
    bis_pkg::in_item_t it;
    int                r;
    r = $urandom_range(99);
    it.slot        = bis_pkg::SLOT_W'($urandom);
    it.key_value   = $urandom;
    it.block_start = bis_pkg::SLOT_W'($urandom);
    if (r < 45) begin
      it.opcode = bis_pkg::OP_WR_DATA;
    end else if (r < 80) begin
      it.opcode = bis_pkg::OP_WR_INDEX;
      if (r < 62) it.slot = bis_pkg::SLOT_W'($urandom_range(INDEX_DEPTH - 1));
    end else begin
      it.opcode = OP_RESERVED;
    end
    send_item(it);
  endtask

  // Mostly keys that are present; also near misses, random keys,
  // the key extremes and block maxima. A few tries to land a safe one.
  task automatic random_search(input int len, input int nblk);
    logic signed [bis_pkg::KEY_W-1:0] key;
    bis_pkg::out_item_t               scratch;
    int                               pos;
    int                               r;
    int                               tries;
    bit                               sent;
    sent = 1'b0;
    for (tries = 0; tries < 4 && !sent; tries++) begin
      pos = $urandom_range(len - 1);
      for (int k = 0; k < 50 && !table_set[pos]; k++) pos = $urandom_range(len - 1);
      // no written entry landed on: try again
      if (!table_set[pos]) continue;
      r = $urandom_range(99);
      if (r < 50) begin
        key = table_keys[pos];
      end else if (r < 65) begin
        key = r[0] ? table_keys[pos] + 1 : table_keys[pos] - 1;
      end else if (r < 75) begin
        key = $urandom;
      end else if (r < 85) begin
        case ($urandom_range(3))
          0:       key = KEY_LO;
          1:       key = KEY_HI;
          2:       key = '0;
          default: key = '1;
        endcase
      end else begin
        key = blk_max[$urandom_range(nblk - 1)];
      end
      if (lookup_key(key, scratch)) begin
        search_for(key);
        sent = 1'b1;
      end
    end
  endtask

  // Well-formed table: len ascending keys (some repeated) cut into nblk
  // contiguous blocks, some possibly empty; each index entry holds its
  // block's top key, or for an empty block the one before it (KEY_LO at first).
  task automatic load_table(input int len, input int nblk);
    int                               firsts[INDEX_DEPTH];
    int                               last;
    int                               tmp;
    int                               j;
    longint                           cur;
    logic signed [bis_pkg::KEY_W-1:0] top;
    cur = ($urandom_range(7) == 0) ? longint'(KEY_LO) : longint'($signed($urandom)) / 2;
    for (int p = 0; p < len; p++) begin
      if (p > 0) cur += ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 1 << 16);
      if (cur > longint'(KEY_HI) || (p == len - 1 && $urandom_range(4) == 0))
        cur = longint'(KEY_HI);
      put_data(p, cur[bis_pkg::KEY_W-1:0]);
    end
    firsts[0] = 0;
    for (int b = 1; b < nblk; b++) begin
      tmp = $urandom_range(len);
      j = b;
      while (j > 1 && firsts[j - 1] > tmp) begin
        firsts[j] = firsts[j - 1];
        j--;
      end
      firsts[j] = tmp;
    end
    top = KEY_LO;
    for (int b = 0; b < nblk; b++) begin
      last = (b == nblk - 1) ? len - 1 : firsts[b + 1] - 1;
      if (last >= firsts[b]) top = table_keys[last];
      put_block(b, top, firsts[b]);
    end
  endtask

  // Small hand-made table: three blocks over eight entries, key extremes,
  // a repeated key, hits and misses, plus transactions the unit ignores.
  task automatic test_basic_lookup();
    write_reg(bis_pkg::REG_TABLE_LENGTH, 11'd8);
    write_reg(bis_pkg::REG_BLOCK_COUNT, 11'd3);
    put_data(0, KEY_LO);
    put_data(1, -5);
    put_data(2, 7);
    put_data(3, 7);
    put_data(4, 20);
    put_data(5, 30);
    put_data(6, 31);
    put_data(7, KEY_HI);
    put_data(DATA_DEPTH - 1, $urandom);
    put_block(0, -5, 0);
    put_block(1, 20, 2);
    put_block(2, KEY_HI, 5);
    put_block(DATA_DEPTH - 1, $urandom, DATA_DEPTH - 1);  // beyond index, dropped
    begin
      bis_pkg::in_item_t it;
      it.opcode      = OP_RESERVED;
      it.slot        = bis_pkg::SLOT_W'($urandom);
      it.key_value   = $urandom;
      it.block_start = bis_pkg::SLOT_W'($urandom);
      send_item(it);
    end
    search_for(KEY_LO);
    search_for(7);        // repeated key: lowest position
    search_for(20);
    search_for(KEY_HI);   // last block runs to table end
    search_for(6);        // miss inside a block
    search_for(25);
    search_for(-4);
  endtask

  // Zero length, zero blocks, and an inverted block.
  task automatic test_corner_cases();
    write_reg(bis_pkg::REG_TABLE_LENGTH, 11'd0);
    search_for(KEY_HI);   // last block ends below its start
    search_for(-5);       // earlier block not bounded by length
    write_reg(bis_pkg::REG_BLOCK_COUNT, 11'd0);
    search_for(7);
    search_for(KEY_LO);
    write_reg(bis_pkg::REG_TABLE_LENGTH, 11'd8);
    write_reg(bis_pkg::REG_BLOCK_COUNT, 11'd3);
    put_block(1, 20, 0);  // block 0 now ends at -1
    search_for(-5);
    search_for(7);
    put_block(1, 20, 2);
    search_for(20);
    search_for(31);
  endtask

  // All 32 index entries; last block at the top of the data store.
  // Registers set past their depths first, then exactly at them.
  task automatic test_full_span();
    int ord;
    ord = 0;
    for (int p = 0; p < 2 * (INDEX_DEPTH - 1); p++) begin
      put_data(p, -2000000000 + ord * 3000000);
      ord++;
    end
    for (int p = 1000; p < DATA_DEPTH; p++) begin
      put_data(p, (p == DATA_DEPTH - 1) ? KEY_HI : -2000000000 + ord * 3000000);
      ord++;
    end
    for (int b = 0; b < INDEX_DEPTH - 1; b++) put_block(b, table_keys[2 * b + 1], 2 * b);
    put_block(INDEX_DEPTH - 1, KEY_HI, 1000);
    write_reg(bis_pkg::REG_TABLE_LENGTH, 11'h7FF);
    write_reg(bis_pkg::REG_BLOCK_COUNT, 11'h7FF);
    search_for(KEY_HI);
    search_for(table_keys[1000]);
    search_for(table_keys[61]);
    search_for(table_keys[0]);
    repeat (16) random_search(DATA_DEPTH, INDEX_DEPTH);
    write_reg(bis_pkg::REG_TABLE_LENGTH, 11'd1024);
    write_reg(bis_pkg::REG_BLOCK_COUNT, 11'd32);
    search_for(KEY_HI);
    search_for(table_keys[1010]);
    repeat (6) random_search(DATA_DEPTH, INDEX_DEPTH);
  endtask

  // Phases of fresh tables with random lookups and some noise.
  // Phase 2 runs with no sender idling; some phases pause mid-way
  // until every answer is back.
  task automatic test_random();
    int goal;
    int phase;
    int len;
    int nblk;
    int n;
    goal  = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal || phase < 3) begin
      steady = (phase == 2);
      len  = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 48);
      nblk = ($urandom_range(6) == 0) ? $urandom_range(1, INDEX_DEPTH) : $urandom_range(1, 6);
      write_reg(bis_pkg::REG_TABLE_LENGTH,
                ($urandom_range(6) == 0) ? bis_pkg::CFG_W'($urandom_range(len))
                                         : bis_pkg::CFG_W'(len));
      write_reg(bis_pkg::REG_BLOCK_COUNT,
                ($urandom_range(9) == 0) ? bis_pkg::CFG_W'($urandom_range(nblk))
                                         : bis_pkg::CFG_W'(nblk));
      load_table(len, nblk);
      n = $urandom_range(20, 45);
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && (phase == 1 || $urandom_range(4) == 0)) wait_for_answers(0);
        if ($urandom_range(99) < 12) noise_item();
        else random_search(len, nblk);
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // Result checker: every strobe must match the oldest owed answer.
  always @(posedge clk) begin
    bis_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (search_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result found=%0b position=%0d",
                   $time, out_item.found, out_item.position);
      end else begin
        want = search_answers.pop_front();
        if (out_item.found !== want.found) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: found mismatch, expected %0b got %0b",
                     $time, want.found, out_item.found);
        end
        if (out_item.position !== want.position) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: position mismatch, expected %0d got %0d",
                     $time, want.position, out_item.position);
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_index      = bis_pkg::REG_TABLE_LENGTH;
    cfg_wdata      = '0;
    len_reg        = '0;
    cnt_reg        = '0;
    mismatch_count = 0;
    items_sent     = 0;
    steady         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_lookup();
    test_corner_cases();
    test_full_span();
    test_random();

    // drain, then leave room for any stray late strobe
    wait_for_answers(TAIL_CYCLES);
    if (mismatch_count == 0 && search_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
